[rtl/per_pixel_histogram_engine_top_assert.svh]
// assertion macros for the histogram engine checker
`ifndef PER_PIXEL_HISTOGRAM_ENGINE_TOP_ASSERT_SVH
`define PER_PIXEL_HISTOGRAM_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define PPH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pph check failed");

// next-cycle implication
`define PPH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pph check failed");

`endif

[rtl/pph_pkg.sv]
// types, constants and helper functions of the histogram engine
`default_nettype none

package pph_pkg;

    localparam int PIXELS     = 1024;
    localparam int MAX_BINS   = 256;
    localparam int PIX_W      = 10;
    localparam int BIN_W      = 8;
    localparam int BINS_W     = 9;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 32;
    localparam int TOT_W      = 48;
    localparam int IDX_W      = 40;
    localparam int BIN_ADDR_W = PIX_W + BIN_W;
    localparam int BIN_DEPTH  = PIXELS * MAX_BINS;
    localparam int CFG_IDX_W  = 2;
    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_BIN_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_IN_USE  = 2'd2;

    localparam logic [DATA_W-1:0] FIRST_BIN_RST    = 32'd0;
    localparam logic [DATA_W-1:0] INV_BIN_SIZE_RST = 32'd65536;
    localparam logic [BINS_W-1:0] BINS_IN_USE_RST  = 9'd256;

    typedef enum logic [1:0] {
        OUTC_UNDER  = 2'd0,
        OUTC_BINNED = 2'd1,
        OUTC_OVER   = 2'd2,
        OUTC_READ   = 2'd3
    } pph_outcome_t;

    typedef struct packed {
        logic              action;
        logic [PIX_W-1:0]  pixel;
        logic [BIN_W-1:0]  bin;
        logic [DATA_W-1:0] intensity;
    } pph_in_t;

    typedef struct packed {
        logic [1:0]        outcome;
        logic [BIN_W-1:0]  bin_index;
        logic [DATA_W-1:0] bin_count;
        logic [DATA_W-1:0] underflow_count;
        logic [DATA_W-1:0] overflow_count;
        logic [TOT_W-1:0]  entry_total;
    } pph_out_t;

    typedef struct packed {
        logic             valid;
        pph_outcome_t     outcome;
        logic [PIX_W-1:0] pixel;
        logic [BIN_W-1:0] bin;
        logic [TOT_W-1:0] total;
    } pph_req_t;

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [TOT_W-1:0] tot_inc(input logic [TOT_W-1:0] v);
        return (&v) ? v : v + TOT_W'(1);
    endfunction

endpackage

`default_nettype wire

[rtl/pph_bin_calc.sv]
// offset, reciprocal multiply, rounding and classification of each word
`default_nettype none

module pph_bin_calc (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  pph_pkg::pph_in_t           in_word,
    input  logic [pph_pkg::DATA_W-1:0] first_bin,
    input  logic [pph_pkg::DATA_W-1:0] inv_bin_size,
    input  logic [pph_pkg::BINS_W-1:0] bins_in_use,
    output pph_pkg::pph_req_t          req
);
    import pph_pkg::*;

    logic             s1_valid_reg;
    pph_in_t          s1_word_reg;
    logic [TOT_W-1:0] total_reg;
    logic [TOT_W-1:0] total_next;

    logic              s2_valid_reg;
    logic              s2_action_reg;
    logic [PIX_W-1:0]  s2_pixel_reg;
    logic [BIN_W-1:0]  s2_bin_reg;
    logic              s2_neg_reg;
    logic [DATA_W-1:0] s2_mag_reg;
    logic [TOT_W-1:0]  s2_total_reg;

    logic              s3_valid_reg;
    logic              s3_action_reg;
    logic [PIX_W-1:0]  s3_pixel_reg;
    logic [BIN_W-1:0]  s3_bin_reg;
    logic              s3_neg_reg;
    logic [IDX_W:0]    s3_prod_reg;
    logic [TOT_W-1:0]  s3_total_reg;

    logic [DATA_W:0]     diff;
    logic [2*DATA_W-1:0] prod;
    logic [IDX_W-1:0]    idx_full;
    logic [BINS_W-1:0]   eff_bins;

    // offset subtraction, exact in 33 bits
    assign diff = {s1_word_reg.intensity[DATA_W-1], s1_word_reg.intensity}
                - {first_bin[DATA_W-1], first_bin};

    assign total_next = (s1_valid_reg && s1_word_reg.action == ACT_ADD) ?
                        tot_inc(total_reg) : total_reg;

    assign prod = (2*DATA_W)'(s2_mag_reg) * (2*DATA_W)'(inv_bin_size);

    // round half up: (p + 2^23) >> 24
    assign idx_full = s3_prod_reg[IDX_W:1] + IDX_W'(s3_prod_reg[0]);
    assign eff_bins = (bins_in_use > BINS_W'(MAX_BINS)) ? BINS_W'(MAX_BINS) : bins_in_use;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            total_reg    <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg   <= in_word;
        s2_action_reg <= s1_word_reg.action;
        s2_pixel_reg  <= s1_word_reg.pixel;
        s2_bin_reg    <= s1_word_reg.bin;
        s2_neg_reg    <= diff[DATA_W];
        s2_mag_reg    <= diff[DATA_W-1:0];
        s2_total_reg  <= total_next;
        s3_action_reg <= s2_action_reg;
        s3_pixel_reg  <= s2_pixel_reg;
        s3_bin_reg    <= s2_bin_reg;
        s3_neg_reg    <= s2_neg_reg;
        s3_prod_reg   <= prod[2*DATA_W-1:2*DATA_W-IDX_W-1];
        s3_total_reg  <= s2_total_reg;
    end

    always_comb
    begin
        req.valid = s3_valid_reg;
        req.pixel = s3_pixel_reg;
        req.total = s3_total_reg;
        req.bin   = '0;
        if (s3_action_reg == ACT_READ)
        begin
            req.outcome = OUTC_READ;
            req.bin     = s3_bin_reg;
        end
        else if (s3_neg_reg)
        begin
            req.outcome = OUTC_UNDER;
        end
        else if (idx_full >= IDX_W'(eff_bins))
        begin
            req.outcome = OUTC_OVER;
        end
        else
        begin
            req.outcome = OUTC_BINNED;
            req.bin     = idx_full[BIN_W-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/pph_store.sv]
// count memories with read-modify-write, forwarding and clearing sweep
`default_nettype none

module pph_store (
    input  logic              clk,
    input  logic              rst_n,
    input  pph_pkg::pph_req_t req,
    output logic              clearing,
    output logic              push,
    output pph_pkg::pph_out_t push_word
);
    import pph_pkg::*;

    logic [CNT_W-1:0]   bin_mem [BIN_DEPTH];
    logic [2*CNT_W-1:0] pix_mem [PIXELS];

    logic [CNT_W-1:0]   bin_rdata_reg;
    logic [2*CNT_W-1:0] pix_rdata_reg;

    logic                  clr_active_reg;
    logic [BIN_ADDR_W-1:0] clr_addr_reg;

    logic             s4_valid_reg;
    pph_outcome_t     s4_outcome_reg;
    logic [PIX_W-1:0] s4_pixel_reg;
    logic [BIN_W-1:0] s4_bin_reg;
    logic [TOT_W-1:0] s4_total_reg;

    logic                  fwd_bin_valid_reg;
    logic [BIN_ADDR_W-1:0] fwd_bin_addr_reg;
    logic [CNT_W-1:0]      fwd_bin_data_reg;
    logic                  fwd_pix_valid_reg;
    logic [PIX_W-1:0]      fwd_pix_addr_reg;
    logic [2*CNT_W-1:0]    fwd_pix_data_reg;

    logic [BIN_ADDR_W-1:0] s4_addr;
    logic [CNT_W-1:0]      bin_cur;
    logic [CNT_W-1:0]      uf_cur;
    logic [CNT_W-1:0]      of_cur;
    logic [CNT_W-1:0]      bin_new;
    logic [CNT_W-1:0]      uf_new;
    logic [CNT_W-1:0]      of_new;
    logic                  s4_bin_we;
    logic                  s4_pix_we;

    logic                  bin_we;
    logic [BIN_ADDR_W-1:0] bin_waddr;
    logic [CNT_W-1:0]      bin_wdata;
    logic                  pix_we;
    logic [PIX_W-1:0]      pix_waddr;
    logic [2*CNT_W-1:0]    pix_wdata;

    assign s4_addr = {s4_pixel_reg, s4_bin_reg};

    // last write bypasses the stale read
    assign bin_cur = (fwd_bin_valid_reg && fwd_bin_addr_reg == s4_addr) ?
                     fwd_bin_data_reg : bin_rdata_reg;
    assign {uf_cur, of_cur} = (fwd_pix_valid_reg && fwd_pix_addr_reg == s4_pixel_reg) ?
                              fwd_pix_data_reg : pix_rdata_reg;

    always_comb
    begin
        bin_new   = bin_cur;
        uf_new    = uf_cur;
        of_new    = of_cur;
        s4_bin_we = 1'b0;
        s4_pix_we = 1'b0;
        push_word.outcome         = s4_outcome_reg;
        push_word.bin_index       = '0;
        push_word.bin_count       = '0;
        push_word.entry_total     = s4_total_reg;
        case (s4_outcome_reg)
            OUTC_UNDER:
            begin
                uf_new    = cnt_inc(uf_cur);
                s4_pix_we = s4_valid_reg;
            end
            OUTC_OVER:
            begin
                of_new    = cnt_inc(of_cur);
                s4_pix_we = s4_valid_reg;
            end
            OUTC_BINNED:
            begin
                bin_new   = cnt_inc(bin_cur);
                s4_bin_we = s4_valid_reg;
                push_word.bin_index = s4_bin_reg;
                push_word.bin_count = DATA_W'(bin_new);
            end
            OUTC_READ:
            begin
                push_word.bin_index = s4_bin_reg;
                push_word.bin_count = DATA_W'(bin_cur);
            end
        endcase
        push_word.underflow_count = DATA_W'(uf_new);
        push_word.overflow_count  = DATA_W'(of_new);
    end

    assign push     = s4_valid_reg;
    assign clearing = clr_active_reg;

    always_comb
    begin
        bin_we    = clr_active_reg || s4_bin_we;
        bin_waddr = clr_active_reg ? clr_addr_reg : s4_addr;
        bin_wdata = clr_active_reg ? '0 : bin_new;
        pix_we    = clr_active_reg || s4_pix_we;
        pix_waddr = clr_active_reg ? clr_addr_reg[PIX_W-1:0] : s4_pixel_reg;
        pix_wdata = clr_active_reg ? '0 : {uf_new, of_new};
    end

    always_ff @(posedge clk)
    begin
        if (bin_we)
        begin
            bin_mem[bin_waddr] <= bin_wdata;
        end
        bin_rdata_reg <= bin_mem[{req.pixel, req.bin}];
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
        begin
            pix_mem[pix_waddr] <= pix_wdata;
        end
        pix_rdata_reg <= pix_mem[req.pixel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg    <= 1'b1;
            clr_addr_reg      <= '0;
            s4_valid_reg      <= 1'b0;
            fwd_bin_valid_reg <= 1'b0;
            fwd_pix_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= req.valid;
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + BIN_ADDR_W'(1);
                if (clr_addr_reg == BIN_ADDR_W'(BIN_DEPTH - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (s4_bin_we)
            begin
                fwd_bin_valid_reg <= 1'b1;
            end
            if (s4_pix_we)
            begin
                fwd_pix_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s4_outcome_reg <= req.outcome;
        s4_pixel_reg   <= req.pixel;
        s4_bin_reg     <= req.bin;
        s4_total_reg   <= req.total;
        if (s4_bin_we)
        begin
            fwd_bin_addr_reg <= s4_addr;
            fwd_bin_data_reg <= bin_new;
        end
        if (s4_pix_we)
        begin
            fwd_pix_addr_reg <= s4_pixel_reg;
            fwd_pix_data_reg <= {uf_new, of_new};
        end
    end

endmodule

`default_nettype wire

[rtl/pph_out_queue.sv]
// result queue between the update stage and the output channel
`default_nettype none

module pph_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pph_pkg::pph_out_t push_word,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output pph_pkg::pph_out_t rsp
);
    import pph_pkg::*;

    pph_out_t          q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              pop;

    assign rsp_valid = (count_reg != '0);
    assign rsp       = q_reg[rd_ptr_reg];
    assign pop       = rsp_valid && !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

[rtl/per_pixel_histogram_engine_top.sv]
// top level of the per-pixel histogram engine
//
// channel   signals                           word
// req       req_valid, req_stall, req         pph_in_t: action, pixel, bin, intensity
// rsp       rsp_valid, rsp_stall, rsp         pph_out_t: outcome, bin, counts, total
// cfg       cfg_valid, cfg_ready, cfg_index   cfg_data: 32-bit register value
//
// one word per cycle while req_stall is low; a result word is offered after
// its request passes the s1 to s4 registers and the result queue; the rate is
// set by the single read-modify-write of each count memory, with the last
// write forwarded to the next read; after reset a clearing pass over all 262144
// bin addresses sweeps the bin and pixel memories and holds req_stall high;
// config writes are taken meanwhile; an 8-word result queue absorbs rsp_stall;
// req_stall rises with 8 words in flight or queued
`default_nettype none

module per_pixel_histogram_engine_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  pph_pkg::pph_in_t              req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output pph_pkg::pph_out_t             rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pph_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pph_pkg::DATA_W-1:0]    cfg_data
);
    import pph_pkg::*;

    logic [DATA_W-1:0] first_bin_reg;
    logic [DATA_W-1:0] inv_bin_size_reg;
    logic [BINS_W-1:0] bins_in_use_reg;
    logic [QCNT_W-1:0] credit_reg;
    logic [QCNT_W-1:0] credit_next;

    logic     clearing;
    logic     accept;
    logic     taken;
    logic     push;
    pph_out_t push_word;
    pph_req_t calc_req;

    assign cfg_ready = 1'b1;
    assign req_stall = clearing || (credit_reg == QCNT_W'(QDEPTH));
    assign accept    = req_valid && !req_stall;
    assign taken     = rsp_valid && !rsp_stall;

    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !taken)
        begin
            credit_next = credit_reg + QCNT_W'(1);
        end
        else if (taken && !accept)
        begin
            credit_next = credit_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_bin_reg    <= FIRST_BIN_RST;
            inv_bin_size_reg <= INV_BIN_SIZE_RST;
            bins_in_use_reg  <= BINS_IN_USE_RST;
            credit_reg       <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FIRST_BIN:    first_bin_reg    <= cfg_data;
                    CFG_INV_BIN_SIZE: inv_bin_size_reg <= cfg_data;
                    CFG_BINS_IN_USE:  bins_in_use_reg  <= cfg_data[BINS_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    pph_bin_calc u_bin_calc (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (accept),
        .in_word      (req),
        .first_bin    (first_bin_reg),
        .inv_bin_size (inv_bin_size_reg),
        .bins_in_use  (bins_in_use_reg),
        .req          (calc_req)
    );

    pph_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (calc_req),
        .clearing  (clearing),
        .push      (push),
        .push_word (push_word)
    );

    pph_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

[rtl/pph_checker.sv]
// port-level checks of the histogram engine, bound to the top level
`default_nettype none

`include "per_pixel_histogram_engine_top_assert.svh"

module pph_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input pph_pkg::pph_out_t rsp
);
    import pph_pkg::*;

    // stalled result word holds
    `PPH_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // underflow and overflow carry no bin
    `PPH_ASSERT_SAME(a_uo_no_bin, rsp_valid && (rsp.outcome == OUTC_UNDER || rsp.outcome == OUTC_OVER), rsp.bin_index == '0 && rsp.bin_count == '0)

    // a binned sample always leaves a nonzero count
    `PPH_ASSERT_SAME(a_binned_nonzero, rsp_valid && rsp.outcome == OUTC_BINNED, rsp.bin_count != '0)

    // add total never goes back between delivered words
    `PPH_ASSERT_NEXT(a_total_mono, rsp_valid && !rsp_stall, !rsp_valid || rsp.entry_total >= $past(rsp.entry_total))

endmodule

bind per_pixel_histogram_engine_top pph_checker u_pph_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

[tb/tb_per_pixel_histogram_engine_top.sv]
// self-checking testbench of the per-pixel histogram engine top level
module tb_per_pixel_histogram_engine_top;
    import pph_pkg::*;

    localparam int QUIET_LIMIT = 800000;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    value;
    } reg_write_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    pph_in_t              req = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    pph_out_t             rsp;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    // shadow of the engine: histograms, side counters and registers
    int unsigned       bin_store[int unsigned];
    logic [CNT_W-1:0]  under_cnt[PIXELS];
    logic [CNT_W-1:0]  over_cnt[PIXELS];
    logic [TOT_W-1:0]  adds_seen = '0;
    logic [DATA_W-1:0] cur_first = FIRST_BIN_RST;
    logic [DATA_W-1:0] cur_inv = INV_BIN_SIZE_RST;
    logic [BINS_W-1:0] cur_bins = BINS_IN_USE_RST;

    pph_in_t    sample_queue[$];
    pph_out_t   due_results[$];
    reg_write_t reg_queue[$];
    pph_out_t   want;

    logic [PIX_W-1:0] hot_pix[6];
    bit          idle_on = 1'b1;
    int          src_gap = 0;
    int          sink_gap = 0;
    int          hold_left = 0;
    int          quiet = 0;
    int          err_count = 0;
    int          results_seen = 0;
    int          adds_taken = 0;
    int          reads_taken = 0;
    int          settings_used = 0;
    int          outcome_hist[4] = '{0, 0, 0, 0};

    per_pixel_histogram_engine_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic pph_out_t bin_sample(input pph_in_t s);
        pph_out_t           r;
        logic signed [32:0] diff;
        logic [64:0]        prod;
        logic [64:0]        idx;
        int unsigned        lim;
        int unsigned        key;
        r = '0;
        if (s.action == ACT_READ)
        begin
            key = {s.pixel, s.bin};
            r.outcome = OUTC_READ;
            r.bin_index = s.bin;
            r.bin_count = bin_store.exists(key) ? bin_store[key] : 0;
        end
        else
        begin
            lim = (cur_bins > MAX_BINS) ? MAX_BINS : cur_bins;
            if (adds_seen != '1)
                adds_seen = adds_seen + 1;
            diff = $signed({s.intensity[31], s.intensity}) - $signed({cur_first[31], cur_first});
            if (diff < 0)
            begin
                r.outcome = OUTC_UNDER;
                if (under_cnt[s.pixel] != '1)
                    under_cnt[s.pixel] = under_cnt[s.pixel] + 1;
            end
            else
            begin
                prod = 65'(diff[31:0]) * 65'(cur_inv);
                idx = (prod + (65'(1) << 23)) >> 24;
                if (idx >= 65'(lim))
                begin
                    r.outcome = OUTC_OVER;
                    if (over_cnt[s.pixel] != '1)
                        over_cnt[s.pixel] = over_cnt[s.pixel] + 1;
                end
                else
                begin
                    key = {s.pixel, idx[BIN_W-1:0]};
                    if (!bin_store.exists(key))
                        bin_store[key] = 0;
                    if (bin_store[key] != 32'hFFFF_FFFF)
                        bin_store[key] = bin_store[key] + 1;
                    r.outcome = OUTC_BINNED;
                    r.bin_index = idx[BIN_W-1:0];
                    r.bin_count = bin_store[key];
                end
            end
        end
        r.underflow_count = under_cnt[s.pixel];
        r.overflow_count = over_cnt[s.pixel];
        r.entry_total = adds_seen;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [TOT_W-1:0] exp_v,
                                        input logic [TOT_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // intensity aimed mostly inside the binned range of the current settings
    function automatic logic [DATA_W-1:0] pick_intensity();
        longint unsigned span;
        int unsigned     lim;
        int              sel;
        lim = (cur_bins > MAX_BINS) ? MAX_BINS : cur_bins;
        if (cur_inv == 0)
            span = 64'hFFFF;
        else
            span = ((64'(lim) + 1) << 24) / cur_inv;
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        sel = $urandom_range(0, 99);
        if (sel < 12)
            return $urandom();
        if (sel < 22)
            return cur_first - 32'($urandom_range(1, 300));
        if (sel < 30)
            return cur_first + span[31:0] - 32'($urandom_range(0, 3));
        return cur_first + $urandom_range(0, span[31:0]);
    endfunction

    task automatic push_item(input logic act, input logic [PIX_W-1:0] pix,
                             input logic [BIN_W-1:0] b, input logic [DATA_W-1:0] val);
        pph_in_t s;
        s.action = act;
        s.pixel = pix;
        s.bin = b;
        s.intensity = val;
        sample_queue.insert(sample_queue.size(), s);
    endtask

    task automatic queue_random(input int n);
        logic [PIX_W-1:0] pix;
        logic [BIN_W-1:0] b;
        int unsigned      lim;
        for (int i = 0; i < n; i++)
        begin
            lim = (cur_bins > MAX_BINS) ? MAX_BINS : cur_bins;
            pix = ($urandom_range(0, 99) < 80) ? hot_pix[$urandom_range(0, 5)] : PIX_W'($urandom());
            if ($urandom_range(0, 99) < 60)
                b = BIN_W'($urandom_range(0, (lim > 0) ? lim - 1 : 0));
            else
                b = BIN_W'($urandom());
            if ($urandom_range(0, 99) < 65)
                push_item(ACT_ADD, pix, BIN_W'($urandom()), pick_intensity());
            else
                push_item(ACT_READ, pix, b, $urandom());
        end
    endtask

    task automatic settle();
        while (sample_queue.size() != 0 || req_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic start_phase(input logic [DATA_W-1:0] first, input logic [DATA_W-1:0] inv,
                               input logic [BINS_W-1:0] bin_num);
        reg_write_t w;
        settle();
        w.idx = CFG_FIRST_BIN;
        w.value = first;
        reg_queue.insert(reg_queue.size(), w);
        w.idx = CFG_INV_BIN_SIZE;
        w.value = inv;
        reg_queue.insert(reg_queue.size(), w);
        w.idx = CFG_BINS_IN_USE;
        w.value = DATA_W'(bin_num);
        reg_queue.insert(reg_queue.size(), w);
        @(posedge clk);
        while (reg_queue.size() != 0 || cfg_valid)
            @(posedge clk);
        foreach (hot_pix[i])
            hot_pix[i] = PIX_W'($urandom());
        settings_used++;
    endtask

    // register writes
    always @(posedge clk or negedge rst_n)
    begin
        reg_write_t w;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= '0;
            cfg_data <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FIRST_BIN:    cur_first = cfg_data;
                    CFG_INV_BIN_SIZE: cur_inv = cfg_data;
                    CFG_BINS_IN_USE:  cur_bins = cfg_data[BINS_W-1:0];
                    default:          ;
                endcase
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_queue.size() != 0)
                begin
                    w = reg_queue.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.idx;
                    cfg_data <= w.value;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                due_results.insert(due_results.size(), bin_sample(req));
                if (req.action == ACT_READ)
                    reads_taken++;
                else
                    adds_taken++;
            end
            if (!req_valid || !req_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    req_valid <= 1'b0;
                end
                else if (idle_on && hold_left == 0 && $urandom_range(0, 11) == 0)
                begin
                    src_gap = $urandom_range(0, 12);
                    req_valid <= 1'b0;
                end
                else if (sample_queue.size() != 0)
                begin
                    req <= sample_queue.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                results_seen++;
                if (due_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    err_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("outcome", TOT_W'(want.outcome), TOT_W'(rsp.outcome));
                    check_field("bin_index", TOT_W'(want.bin_index), TOT_W'(rsp.bin_index));
                    check_field("bin_count", TOT_W'(want.bin_count), TOT_W'(rsp.bin_count));
                    check_field("underflow_count", TOT_W'(want.underflow_count),
                                TOT_W'(rsp.underflow_count));
                    check_field("overflow_count", TOT_W'(want.overflow_count),
                                TOT_W'(rsp.overflow_count));
                    check_field("entry_total", want.entry_total, rsp.entry_total);
                    outcome_hist[rsp.outcome]++;
                end
                // long back-pressure so the engine fills up
                if (results_seen == 300)
                    hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                rsp_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                sink_gap = $urandom_range(0, 12);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", quiet);
                $display("Some tests failed");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        foreach (under_cnt[i])
        begin
            under_cnt[i] = '0;
            over_cnt[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: one bin per 256 intensity units
        start_phase(32'd0, 32'd65536, 9'd256);
        push_item(ACT_ADD, 10'd0, 8'd0, 32'd0);
        push_item(ACT_ADD, 10'd1023, 8'd0, 32'd127);
        push_item(ACT_ADD, 10'd1023, 8'd0, 32'd128);
        push_item(ACT_ADD, 10'd0, 8'd0, 32'd65280);
        push_item(ACT_ADD, 10'd0, 8'd0, 32'd65408);
        push_item(ACT_ADD, 10'd1023, 8'd0, 32'hFFFF_FFFF);
        push_item(ACT_ADD, 10'd0, 8'd0, 32'h8000_0000);
        push_item(ACT_ADD, 10'd1023, 8'd0, 32'h7FFF_FFFF);
        push_item(ACT_READ, 10'd0, 8'd0, 32'd0);
        push_item(ACT_READ, 10'd1023, 8'd1, 32'd0);
        push_item(ACT_READ, 10'd0, 8'd255, 32'd0);
        push_item(ACT_READ, 10'd5, 8'd200, 32'd0);
        push_item(ACT_ADD, 10'd0, 8'd255, 32'd0);
        push_item(ACT_READ, 10'd0, 8'd0, 32'hFFFF_FFFF);
        for (int i = 0; i < 3; i++)
            push_item(ACT_ADD, 10'd7, 8'd0, 32'd512);
        push_item(ACT_READ, 10'd7, 8'd2, 32'd0);
        queue_random(180);

        // offset base, bins of 128 intensity units, few bins
        start_phase(32'hFFFF_D800, 32'd131072, 9'd16);
        queue_random(260);

        // most negative base, widest reciprocal, single bin
        start_phase(32'h8000_0000, 32'hFFFF_FFFF, 9'd1);
        push_item(ACT_ADD, 10'd3, 8'd0, 32'h8000_0000);
        push_item(ACT_ADD, 10'd3, 8'd0, 32'h8000_0001);
        queue_random(90);

        // most positive base, smallest nonzero reciprocal, bin count above the maximum
        start_phase(32'h7FFF_FFFF, 32'd1, 9'd511);
        push_item(ACT_ADD, 10'd9, 8'd0, 32'h7FFF_FFFF);
        push_item(ACT_ADD, 10'd9, 8'd0, 32'h7FFF_FFFE);
        queue_random(90);

        // zero reciprocal with no bins
        start_phase(32'd0, 32'd0, 9'd0);
        push_item(ACT_ADD, 10'd11, 8'd0, 32'd0);
        push_item(ACT_ADD, 10'd11, 8'd0, 32'h7FFF_FFFF);
        queue_random(60);

        // zero reciprocal with bins
        start_phase(32'd0, 32'd0, 9'd300);
        push_item(ACT_ADD, 10'd12, 8'd0, 32'h7FFF_FFFF);
        queue_random(60);

        for (int p = 0; p < 3; p++)
        begin
            start_phase(32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000,
                        32'($urandom_range(32'h1000, 32'h10_0000)),
                        9'($urandom_range(1, 40)));
            if (p == 2)
                idle_on = 1'b0;
            queue_random(130);
        end

        settle();
        $display("covered %0d samples and %0d reads over %0d register settings",
                 adds_taken, reads_taken, settings_used);
        $display("outcomes seen: %0d underflow, %0d binned, %0d overflow, %0d read",
                 outcome_hist[OUTC_UNDER], outcome_hist[OUTC_BINNED],
                 outcome_hist[OUTC_OVER], outcome_hist[OUTC_READ]);
        if (err_count == 0 && due_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
